FILE: sv/mfsk_pkg.sv
`default_nettype none

package mfsk_pkg;

  // field widths fixed by the stream format
  localparam int SAMPLE_W = 15;
  localparam int SYMBOL_W = 3;
  localparam int TONE_W   = 4;
  localparam int LENGTH_W = 16;

  // defaults for top-level parameters
  localparam int TABLE_POINTS_DEFAULT = 100;
  localparam int QUEUE_DEPTH_DEFAULT  = 4;

  // sine table scaling
  localparam int  AMPLITUDE = 16383;
  localparam real HALF_PI   = 1.5707963267948966;

  localparam logic [TONE_W-1:0]   SEPARATOR_TONE       = 4'd1;
  localparam logic [LENGTH_W-1:0] SEGMENT_LENGTH_RESET = 16'd10000;

  // segment sequencer states
  typedef enum logic [1:0] {
    KIND_LEAD,
    KIND_TONE,
    KIND_SEP,
    KIND_DONE
  } kind_t;

  // per-beat flags, symbol_taken in the low bit
  typedef struct packed {
    logic done;
    logic taken;
  } beat_flags_t;

  // symbol value to tone number
  function automatic logic [TONE_W-1:0] tone_of_symbol(input logic [SYMBOL_W-1:0] sym);
    logic [TONE_W-1:0] tone;
    unique case (sym)
      3'b000: tone = 4'd3;
      3'b001: tone = 4'd5;
      3'b010: tone = 4'd2;
      3'b011: tone = 4'd9;
      3'b100: tone = 4'd4;
      3'b101: tone = 4'd7;
      3'b110: tone = 4'd6;
      3'b111: tone = 4'd10;
    endcase
    return tone;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mfsk_front.sv
`default_nettype none

module mfsk_front #(
  parameter int TABLE_POINTS = mfsk_pkg::TABLE_POINTS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  accept,
  input  wire logic [mfsk_pkg::SYMBOL_W-1:0]         symbol_bits,
  input  wire logic                                  last_symbol,
  input  wire logic [mfsk_pkg::LENGTH_W-1:0]         segment_length,
  output logic [$clog2(TABLE_POINTS)-1:0]            push_idx,
  output mfsk_pkg::beat_flags_t                      push_flags,
  output mfsk_pkg::kind_t                            kind
);

  localparam int IdxW = $clog2(TABLE_POINTS);

  mfsk_pkg::kind_t                    kind_next;
  logic [mfsk_pkg::LENGTH_W-1:0]      pos, pos_next;
  logic [mfsk_pkg::TONE_W-1:0]        tone, tone_next, tone_eff;
  logic [IdxW-1:0]                    acc, acc_next;
  logic                               final_flag, final_flag_next;
  logic                               latch, seg_end;
  logic [IdxW:0]                      acc_sum;

  // symbol latch on first tick of a tone segment
  assign latch    = (kind == mfsk_pkg::KIND_TONE) && (pos == '0);
  assign tone_eff = latch ? mfsk_pkg::tone_of_symbol(symbol_bits) : tone;
  assign seg_end  = ({1'b0, pos} + 17'd1) >= {1'b0, segment_length};

  // table index advances by the tone number, modulo table size
  assign acc_sum = {1'b0, acc} + (IdxW+1)'(tone_eff);

  assign push_idx         = acc;
  assign push_flags.taken = latch;
  assign push_flags.done  = (kind == mfsk_pkg::KIND_DONE);

  // next state
  always_comb begin
    kind_next       = kind;
    pos_next        = pos;
    tone_next       = tone;
    acc_next        = acc;
    final_flag_next = final_flag;
    if (accept && kind != mfsk_pkg::KIND_DONE) begin
      tone_next = tone_eff;
      if (latch) begin
        final_flag_next = last_symbol;
      end
      if (seg_end) begin
        pos_next = '0;
        acc_next = '0;
        unique case (kind)
          mfsk_pkg::KIND_TONE: begin
            kind_next = mfsk_pkg::KIND_SEP;
            tone_next = mfsk_pkg::SEPARATOR_TONE;
          end
          mfsk_pkg::KIND_SEP: begin
            kind_next = final_flag ? mfsk_pkg::KIND_DONE : mfsk_pkg::KIND_TONE;
          end
          mfsk_pkg::KIND_LEAD: begin
            kind_next = mfsk_pkg::KIND_TONE;
          end
          default: begin
            kind_next = kind;
          end
        endcase
      end else begin
        pos_next = pos + 16'd1;
        if (acc_sum >= (IdxW+1)'(TABLE_POINTS)) begin
          acc_next = IdxW'(acc_sum - (IdxW+1)'(TABLE_POINTS));
        end else begin
          acc_next = acc_sum[IdxW-1:0];
        end
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      kind       <= mfsk_pkg::KIND_LEAD;
      pos        <= '0;
      tone       <= mfsk_pkg::SEPARATOR_TONE;
      acc        <= '0;
      final_flag <= 1'b0;
    end else begin
      kind       <= kind_next;
      pos        <= pos_next;
      tone       <= tone_next;
      acc        <= acc_next;
      final_flag <= final_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mfsk_queue.sv
`default_nettype none

module mfsk_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mfsk_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = store[rd_ptr];

  // entry write
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/mfsk_back.sv
`default_nettype none

module mfsk_back #(
  parameter int TABLE_POINTS = mfsk_pkg::TABLE_POINTS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_valid,
  input  wire logic [$clog2(TABLE_POINTS)-1:0]     q_idx,
  input  wire mfsk_pkg::beat_flags_t               q_flags,
  output logic                                     pop,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [mfsk_pkg::SAMPLE_W-1:0]     out_sample,
  output mfsk_pkg::beat_flags_t                    out_flags
);

  logic signed [mfsk_pkg::SAMPLE_W-1:0] rom [TABLE_POINTS];

  // sine table: quadrant folded, magnitude truncated, sign applied after
  for (genvar m = 0; m < TABLE_POINTS; m++) begin : g_rom
    localparam int  Quad   = ((4 * m) / TABLE_POINTS) % 4;
    localparam int  Offs   = (4 * m) % TABLE_POINTS;
    localparam real Angle  = mfsk_pkg::HALF_PI * Offs / TABLE_POINTS;
    localparam real Unit   = (Quad % 2 == 0) ? $sin(Angle) : $cos(Angle);
    localparam int  MagRaw = $rtoi(mfsk_pkg::AMPLITUDE * Unit);
    localparam int  Mag    = (MagRaw > mfsk_pkg::AMPLITUDE) ? mfsk_pkg::AMPLITUDE : MagRaw;
    localparam int  Value  = (Quad >= 2) ? -Mag : Mag;
    assign rom[m] = mfsk_pkg::SAMPLE_W'(Value);
  end

  assign pop = q_valid && (!out_valid || out_ready);

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // table read into output register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_sample <= q_flags.done ? '0 : rom[q_idx];
      out_flags  <= q_flags;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mfsk_tone_modulator.sv
// channel   dir  beat contents
// s_axis    in   tdata[2:0] symbol_bits, tlast last_symbol
// m_axis    out  tdata[14:0] sample, tuser[0] symbol_taken, tuser[1] done_res
// cfg       in   cfg_wr_data segment_length, written when cfg_wr_en is high
//
// one sample out per beat in; a beat is taken every cycle while the queue has room
// an input beat passes through the queue entry, then the table read into the output register
// rst is synchronous; after it the leading separator plays, segment length 10000
// an output stall fills the queue, then s_axis_tready drops until a slot frees
`default_nettype none

module mfsk_tone_modulator #(
  parameter int TABLE_POINTS = mfsk_pkg::TABLE_POINTS_DEFAULT,
  parameter int QUEUE_DEPTH  = mfsk_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [2:0] symbol_bits
  input  wire logic        s_axis_tlast,   // last_symbol
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [14:0] sample
  output logic [1:0]       m_axis_tuser,   // [0] symbol_taken, [1] done_res
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data     // segment_length
);

  localparam int IdxW = $clog2(TABLE_POINTS);
  localparam int CmdW = IdxW + $bits(mfsk_pkg::beat_flags_t);

  logic [mfsk_pkg::LENGTH_W-1:0]        segment_length;
  logic                                 accept, q_full, q_valid, q_pop;
  logic [IdxW-1:0]                      push_idx, q_idx;
  mfsk_pkg::beat_flags_t                push_flags, q_flags, out_flags;
  mfsk_pkg::kind_t                      front_kind;
  logic [CmdW-1:0]                      q_head;
  logic signed [mfsk_pkg::SAMPLE_W-1:0] out_sample;

  // segment length register
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_length <= mfsk_pkg::SEGMENT_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      segment_length <= cfg_wr_data;
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front: segment sequencing
  mfsk_front #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .symbol_bits   (s_axis_tdata[mfsk_pkg::SYMBOL_W-1:0]),
    .last_symbol   (s_axis_tlast),
    .segment_length(segment_length),
    .push_idx      (push_idx),
    .push_flags    (push_flags),
    .kind          (front_kind)
  );

  // command queue between front and back
  mfsk_queue #(
    .WIDTH(CmdW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data({push_flags, push_idx}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_head),
    .not_empty(q_valid)
  );

  assign q_idx   = q_head[IdxW-1:0];
  assign q_flags = q_head[CmdW-1:IdxW];

  // back: table lookup and output register
  mfsk_back #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_idx     (q_idx),
    .q_flags   (q_flags),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_sample(out_sample),
    .out_flags (out_flags)
  );

  assign m_axis_tdata = {1'b0, out_sample};
  assign m_axis_tuser = out_flags;

  // once done, the sequencer never leaves it
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    front_kind == mfsk_pkg::KIND_DONE |=> front_kind == mfsk_pkg::KIND_DONE)
    else $error("sequencer left done state");

  // done beats carry silence and never a taken symbol
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 16'd0 && !m_axis_tuser[0])
    else $error("done beat with sample or symbol");

  // table index from the phase step stays inside the table
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> {1'b0, q_idx} < (IdxW+1)'(TABLE_POINTS))
    else $error("table index out of range");

endmodule

`default_nettype wire

FILE: bench/mfsk_tone_modulator_tb.sv
`default_nettype none

module mfsk_tone_modulator_tb;
  import mfsk_pkg::*;

  localparam int POINTS      = TABLE_POINTS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_FROM  = 300;
  localparam int QUIET_TO    = 700;
  localparam int ITEM_TARGET = 600;

  // modulator state as the predictor tracks it
  typedef struct packed {
    kind_t             kind;
    logic [15:0]       pos;
    logic [TONE_W-1:0] tone;
    logic [6:0]        phase;
    logic              final_sym;
    logic              finished;
  } mod_state_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] sym;
    logic                last;
  } symbol_beat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                taken;
    logic                done;
  } tone_beat_t;

  logic clk;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic [SYMBOL_W-1:0] in_sym   = '0;
  logic                in_last  = 1'b0;
  logic                s_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [15:0]         out_data;
  logic [1:0]          out_flags;
  logic                cfg_en   = 1'b0;
  logic [15:0]         cfg_data = '0;

  logic [SAMPLE_W-1:0] sine_table [0:POINTS-1];
  logic [TONE_W-1:0]   tone_map [0:7];

  mod_state_t   mod_state;
  logic [15:0]  seg_len;
  symbol_beat_t symbols_pending [$];
  tone_beat_t   samples_expected [$];

  int cycle_count    = 0;
  int beats_queued   = 0;
  int beats_accepted = 0;
  int samples_seen   = 0;
  int symbols_taken  = 0;
  int length_writes  = 0;
  int fail_count     = 0;

  mfsk_tone_modulator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  ({5'd0, in_sym}),   // [2:0] symbol_bits
    .s_axis_tlast  (in_last),          // last_symbol
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),         // [14:0] sample
    .m_axis_tuser  (out_flags),        // [0] symbol_taken, [1] done_res
    .cfg_wr_en     (cfg_en),
    .cfg_wr_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random stalls, none inside the quiet window
  function automatic bit take_break();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < 15;
  endfunction

  // one sample tick of the modulator
  function automatic void modulate_tick(inout mod_state_t st, input logic [15:0] len,
                                        input logic [SYMBOL_W-1:0] sym, input logic last,
                                        output tone_beat_t res);
    int prod;
    res = '0;
    if (st.kind == KIND_DONE) begin
      res.done = 1'b1;
    end else begin
      // symbol latch on the first tick of a tone segment
      if (st.kind == KIND_TONE && st.pos == 16'd0) begin
        st.tone      = tone_map[sym];
        st.final_sym = last;
        res.taken    = 1'b1;
      end
      prod = (int'(st.tone) * int'(st.phase)) % POINTS;
      res.sample = sine_table[prod];
      // segment end, also when the length shrank below the position
      if ({1'b0, st.pos} + 17'd1 >= {1'b0, len}) begin
        st.pos   = '0;
        st.phase = '0;
        if (st.kind == KIND_TONE) begin
          st.kind = KIND_SEP;
          st.tone = SEPARATOR_TONE;
        end else if (st.kind == KIND_SEP && st.final_sym) begin
          st.kind     = KIND_DONE;
          st.finished = 1'b1;
        end else begin
          st.kind = KIND_TONE;
        end
      end else begin
        st.pos   = st.pos + 16'd1;
        st.phase = (st.phase == 7'(POINTS - 1)) ? 7'd0 : st.phase + 7'd1;
      end
    end
  endfunction

  // driver: offers pending symbol beats, predicts on acceptance
  always @(posedge clk) begin : drive
    tone_beat_t   res;
    symbol_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && s_ready) begin
        modulate_tick(mod_state, seg_len, in_sym, in_last, res);
        samples_expected.push_back(res);
        beats_accepted++;
      end
      if (!in_valid || s_ready) begin
        if (symbols_pending.size() != 0 && !take_break()) begin
          nxt = symbols_pending.pop_front();
          in_valid <= 1'b1;
          in_sym   <= nxt.sym;
          in_last  <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each sample beat with the oldest prediction
  always @(posedge clk) begin : watch
    tone_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        samples_seen++;
        if (samples_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected sample beat %0d: sample %0d flags %b", samples_seen,
                     $signed(out_data[14:0]), out_flags);
          end
        end else begin
          want = samples_expected.pop_front();
          if (want.taken) symbols_taken++;
          if (out_data[14:0] !== want.sample || out_flags[0] !== want.taken ||
              out_flags[1] !== want.done) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display({"mismatch at sample beat %0d: expected sample %0d taken %0b",
                        " done %0b, got sample %0d taken %0b done %0b"},
                       samples_seen, $signed(want.sample), want.taken, want.done,
                       $signed(out_data[14:0]), out_flags[0], out_flags[1]);
            end
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (beats_accepted != beats_queued || samples_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [15:0] len);
    @(posedge clk);
    cfg_en   <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_en  <= 1'b0;
    seg_len = len;
    length_writes++;
  endtask

  task automatic push_symbol(input logic [SYMBOL_W-1:0] sym, input logic last);
    symbol_beat_t b;
    b.sym  = sym;
    b.last = last;
    symbols_pending.push_back(b);
    beats_queued++;
  endtask

  // random symbol beats; on a latching tick last is raised only when ending the message
  task automatic queue_symbols(input int count, input bit end_message);
    mod_state_t          ahead;
    tone_beat_t          res;
    logic [SYMBOL_W-1:0] sym;
    logic                last;
    int                  n;
    int                  tail;
    ahead = mod_state;
    n     = 0;
    tail  = 0;
    while (end_message ? (tail < 8) : (n < count)) begin
      sym  = $urandom_range(7);
      last = $urandom_range(1);
      if (ahead.kind == KIND_TONE && ahead.pos == 16'd0) last = end_message;
      modulate_tick(ahead, seg_len, sym, last, res);
      push_symbol(sym, last);
      n++;
      if (ahead.kind == KIND_DONE) tail++;
    end
  endtask

  initial begin : stimulus
    int   m;
    int   mag;
    real  v;
    int   phase_no;
    int   count;
    int   items;
    logic [15:0] len;

    // sine table and tone map
    for (m = 0; m < POINTS; m++) begin
      v   = AMPLITUDE * $sin(2.0 * 3.141592653589793 * m / POINTS);
      mag = $rtoi(((v < 0.0) ? -v : v) + 1.0e-6);
      if (mag > AMPLITUDE) mag = AMPLITUDE;
      sine_table[m] = SAMPLE_W'((v < 0.0) ? -mag : mag);
    end
    tone_map[0] = 4'd3;
    tone_map[1] = 4'd5;
    tone_map[2] = 4'd2;
    tone_map[3] = 4'd9;
    tone_map[4] = 4'd4;
    tone_map[5] = 4'd7;
    tone_map[6] = 4'd6;
    tone_map[7] = 4'd10;

    mod_state.kind      = KIND_LEAD;
    mod_state.pos       = '0;
    mod_state.tone      = SEPARATOR_TONE;
    mod_state.phase     = '0;
    mod_state.final_sym = 1'b0;
    mod_state.finished  = 1'b0;
    seg_len             = SEGMENT_LENGTH_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // leading separator at the reset length
    queue_symbols(5, 1'b0);
    wait_drained();

    // one-sample segments: cut the lead short, then every symbol once;
    // last is raised only on ticks that ignore it
    write_length(16'd1);
    for (m = 0; m < 17; m++) begin
      push_symbol(3'((m - 1) >> 1), (m % 2) == 0);
    end
    wait_drained();

    // zero length behaves as one
    write_length(16'd0);
    queue_symbols(4, 1'b0);
    wait_drained();

    // random phases, each with its own segment length
    items    = 0;
    phase_no = 0;
    while (items < ITEM_TARGET) begin
      if (phase_no == 1) begin
        len = 16'hFFFF;
      end else begin
        case ($urandom_range(9))
          0:       len = 16'hFFFF;
          1, 2:    len = 16'($urandom_range(1, 6));
          3, 4, 5: len = 16'($urandom_range(2, 40));
          6:       len = 16'(POINTS);
          default: len = 16'($urandom_range(90, 210));
        endcase
      end
      write_length(len);
      count = $urandom_range(30, 80);
      queue_symbols(count, 1'b0);
      wait_drained();
      items += count;
      phase_no++;
    end

    // final symbol, closing separator, then a few ticks in the done state
    write_length(16'($urandom_range(2, 6)));
    queue_symbols(0, 1'b1);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("checked %0d sample beats from %0d symbol beats, %0d symbols latched",
             samples_seen, beats_accepted, symbols_taken);
    $display("%0d segment length settings, message ended in the done state", length_writes);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/mfsk_pkg.sv
sv/mfsk_front.sv
sv/mfsk_queue.sv
sv/mfsk_back.sv
sv/mfsk_tone_modulator.sv
bench/mfsk_tone_modulator_tb.sv
